FILE: design/letter_digit_command_parser_macros.svh
// assertion macros shared by the parser checker
// no dependencies
`ifndef LETTER_DIGIT_COMMAND_PARSER_MACROS_SVH
`define LETTER_DIGIT_COMMAND_PARSER_MACROS_SVH

// checked only while reset is released
`define LDCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LDCP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ldcp_pkg.sv
// types and character codes for the letter and digit command parser
// no dependencies
package ldcp_pkg;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam logic EVENT_CMD  = 1'b0;
    localparam logic EVENT_HELP = 1'b1;

    localparam logic [7:0] CHAR_HELP    = 8'h3F;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [7:0] CMD_CHANNEL  = 8'h43;
    localparam logic [7:0] CMD_SENS     = 8'h53;
    localparam logic [7:0] CMD_MIX      = 8'h46;
    localparam logic [7:0] CMD_EXPONENT = 8'h45;
    localparam logic [7:0] CMD_SW_MIX   = 8'h4D;
    localparam logic [7:0] CMD_SW_LR    = 8'h4C;
    localparam logic [7:0] CMD_SW_UD    = 8'h55;
    localparam logic [7:0] CMD_SW_SWAP  = 8'h41;
    localparam logic [7:0] CMD_VERBOSE  = 8'h56;

    localparam logic [3:0] SW_MIX  = 4'b0001;
    localparam logic [3:0] SW_LR   = 4'b0010;
    localparam logic [3:0] SW_UD   = 4'b0100;
    localparam logic [3:0] SW_SWAP = 4'b1000;

    localparam logic [1:0]  MAX_DIGITS      = 2'd3;
    localparam logic [9:0]  MAX_VALUE       = 10'd999;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] command_letter;
        logic [9:0] command_value;
        logic       stored_changed;
        logic [9:0] channel_out;
        logic [9:0] sensitivity_out;
        logic [9:0] mix_factor_out;
        logic [9:0] exponent_out;
        logic [3:0] switches_out;
        logic       verbose_out;
    } t_result;

    typedef struct packed {
        logic [7:0]  pending_letter;
        logic [1:0]  digit_count;
        logic [9:0]  value_accum;
        logic [15:0] elapsed_ticks;
    } t_parse_state;

    typedef struct packed {
        logic [9:0] channel;
        logic [9:0] sensitivity;
        logic [9:0] mix_factor;
        logic [9:0] exponent;
        logic [3:0] switch_bits;
        logic       verbose;
    } t_settings;

endpackage

FILE: design/letter_digit_command_parser.sv
// letter and digit command parser: top level with state and output buffer
// depends on ldcp_pkg and ldcp_step
// a result is registered in the output register, or the skid register if output stalls
// throughput: one transaction per cycle; a two-entry output buffer (output register and
// skid register) holds input off only while the skid register holds a waiting result
// reset: synchronous, active low; clears parser state, settings and buffer, and sets
// the timeout register to 1000 ticks
module letter_digit_command_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ldcp_pkg::t_item     i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ldcp_pkg::t_result   o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    ldcp_pkg::t_parse_state r_parse, n_parse, step_parse;
    ldcp_pkg::t_settings    r_set, n_set, step_set;
    logic [15:0]            r_timeout, n_timeout;
    logic                   r_out_valid, n_out_valid;
    logic                   r_skid_valid, n_skid_valid;
    ldcp_pkg::t_result      r_out, n_out;
    ldcp_pkg::t_result      r_skid, n_skid;
    ldcp_pkg::t_result      step_result;
    logic                   step_valid;
    logic                   in_accept;
    logic                   out_free;
    logic                   res_valid;

    ldcp_step u_step (
        .i_item   (i_in_data),
        .i_parse  (r_parse),
        .i_set    (r_set),
        .i_timeout(r_timeout),
        .o_parse  (step_parse),
        .o_set    (step_set),
        .o_valid  (step_valid),
        .o_result (step_result)
    );

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign res_valid = in_accept && step_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_parse      = in_accept ? step_parse : r_parse;
        n_set        = in_accept ? step_set : r_set;
        n_timeout    = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_timeout;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out       = step_result;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse      <= '0;
            r_set        <= '0;
            r_timeout    <= ldcp_pkg::TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_parse      <= n_parse;
            r_set        <= n_set;
            r_timeout    <= n_timeout;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

FILE: design/ldcp_step.sv
// next parser state, settings and result for one transaction
// depends on ldcp_pkg
module ldcp_step (
    input  ldcp_pkg::t_item        i_item,
    input  ldcp_pkg::t_parse_state i_parse,
    input  ldcp_pkg::t_settings    i_set,
    input  logic [15:0]            i_timeout,
    output ldcp_pkg::t_parse_state o_parse,
    output ldcp_pkg::t_settings    o_set,
    output logic                   o_valid,
    output ldcp_pkg::t_result      o_result
);

    logic [7:0]  c;
    logic        pending;
    logic        is_letter;
    logic        is_digit;
    logic [15:0] elapsed_inc;
    logic [13:0] acc_wide;
    logic [9:0]  acc_next;
    logic [1:0]  count_next;
    logic        apply;
    logic [9:0]  apply_val;
    logic        changed;

    assign c         = i_item.data_byte;
    assign pending   = (i_parse.pending_letter != 8'd0);
    assign is_letter = ((c >= ldcp_pkg::CHAR_LOWER_A) && (c <= ldcp_pkg::CHAR_LOWER_Z))
                    || ((c >= ldcp_pkg::CHAR_UPPER_A) && (c <= ldcp_pkg::CHAR_UPPER_Z));
    assign is_digit  = (c >= ldcp_pkg::CHAR_ZERO) && (c <= ldcp_pkg::CHAR_NINE);

    assign elapsed_inc = (i_parse.elapsed_ticks == ldcp_pkg::ELAPSED_MAX)
                       ? i_parse.elapsed_ticks : i_parse.elapsed_ticks + 16'd1;

    // value * 10 + digit, kept to ten bits
    assign acc_wide   = ({4'd0, i_parse.value_accum} << 3) + ({4'd0, i_parse.value_accum} << 1)
                      + {10'd0, c[3:0]};
    assign acc_next   = acc_wide[9:0];
    assign count_next = i_parse.digit_count + 2'd1;

    always_comb begin
        o_parse   = i_parse;
        o_set     = i_set;
        o_valid   = 1'b0;
        apply     = 1'b0;
        apply_val = i_parse.value_accum;
        changed   = 1'b0;
        o_result  = '0;

        if (i_item.kind == ldcp_pkg::KIND_TICK) begin
            o_parse.elapsed_ticks = elapsed_inc;
            if (pending && (i_parse.digit_count != 2'd0) && (elapsed_inc > i_timeout)) begin
                apply = 1'b1;
            end
        end else if (c == ldcp_pkg::CHAR_HELP) begin
            o_valid             = 1'b1;
            o_result.event_kind = ldcp_pkg::EVENT_HELP;
        end else if (is_letter) begin
            o_parse.pending_letter = c;
            o_parse.digit_count    = 2'd0;
            o_parse.value_accum    = 10'd0;
            o_parse.elapsed_ticks  = 16'd0;
        end else if (pending && is_digit) begin
            o_parse.value_accum = acc_next;
            o_parse.digit_count = count_next;
            if (count_next == ldcp_pkg::MAX_DIGITS) begin
                apply     = 1'b1;
                apply_val = acc_next;
            end
        end else if (pending && (i_parse.digit_count != 2'd0)) begin
            apply = 1'b1;
        end

        if (apply) begin
            changed = 1'b1;
            unique case (i_parse.pending_letter)
                ldcp_pkg::CMD_CHANNEL:  o_set.channel     = apply_val;
                ldcp_pkg::CMD_SENS:     o_set.sensitivity = apply_val;
                ldcp_pkg::CMD_MIX:      o_set.mix_factor  = apply_val;
                ldcp_pkg::CMD_EXPONENT: o_set.exponent    = apply_val;
                ldcp_pkg::CMD_SW_MIX:   o_set.switch_bits = (apply_val != 10'd0)
                    ? (i_set.switch_bits | ldcp_pkg::SW_MIX)
                    : (i_set.switch_bits & ~ldcp_pkg::SW_MIX);
                ldcp_pkg::CMD_SW_LR:    o_set.switch_bits = (apply_val != 10'd0)
                    ? (i_set.switch_bits | ldcp_pkg::SW_LR)
                    : (i_set.switch_bits & ~ldcp_pkg::SW_LR);
                ldcp_pkg::CMD_SW_UD:    o_set.switch_bits = (apply_val != 10'd0)
                    ? (i_set.switch_bits | ldcp_pkg::SW_UD)
                    : (i_set.switch_bits & ~ldcp_pkg::SW_UD);
                ldcp_pkg::CMD_SW_SWAP:  o_set.switch_bits = (apply_val != 10'd0)
                    ? (i_set.switch_bits | ldcp_pkg::SW_SWAP)
                    : (i_set.switch_bits & ~ldcp_pkg::SW_SWAP);
                ldcp_pkg::CMD_VERBOSE: begin
                    o_set.verbose = (apply_val != 10'd0);
                    changed       = 1'b0;
                end
                default:                changed = 1'b0;
            endcase
            o_parse.pending_letter  = 8'd0;
            o_parse.digit_count     = 2'd0;
            o_parse.value_accum     = 10'd0;
            o_valid                 = 1'b1;
            o_result.event_kind     = ldcp_pkg::EVENT_CMD;
            o_result.command_letter = i_parse.pending_letter;
            o_result.command_value  = apply_val;
            o_result.stored_changed = changed;
        end

        o_result.channel_out     = o_set.channel;
        o_result.sensitivity_out = o_set.sensitivity;
        o_result.mix_factor_out  = o_set.mix_factor;
        o_result.exponent_out    = o_set.exponent;
        o_result.switches_out    = o_set.switch_bits;
        o_result.verbose_out     = o_set.verbose;
    end

endmodule

FILE: design/ldcp_checker.sv
// port-level checks for the letter and digit command parser, bound to the top level
// depends on ldcp_pkg and letter_digit_command_parser_macros.svh
`include "letter_digit_command_parser_macros.svh"

module ldcp_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  ldcp_pkg::t_result   o_out_data
);

    logic changed_letter;

    assign changed_letter = (o_out_data.command_letter == ldcp_pkg::CMD_CHANNEL)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_SENS)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_MIX)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_EXPONENT)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_SW_MIX)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_SW_LR)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_SW_UD)
                         || (o_out_data.command_letter == ldcp_pkg::CMD_SW_SWAP);

    // no transaction left in the buffer after reset
    `LDCP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    `LDCP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    `LDCP_ASSERT(a_help_fields, i_clk, i_rst_n, (o_out_valid && (o_out_data.event_kind == ldcp_pkg::EVENT_HELP)) |-> ((o_out_data.command_letter == 8'd0) && (o_out_data.command_value == 10'd0) && !o_out_data.stored_changed), "help event carries command fields")

    `LDCP_ASSERT(a_value_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.command_value <= ldcp_pkg::MAX_VALUE), "command value beyond three digits")

    `LDCP_ASSERT(a_changed_letter, i_clk, i_rst_n, (o_out_valid && o_out_data.stored_changed) |-> changed_letter, "stored change from a non-storing letter")

endmodule

bind letter_digit_command_parser ldcp_checker u_ldcp_checker (.*);
